@@ sv/ltts_pkg.sv @@
// Shared types, constants and ordering function for the timeline task scheduler.
// No dependencies; imported by looping_timeline_task_scheduler_top and its testbench.
package ltts_pkg;

    localparam int MAX_TASKS = 64;
    localparam int KEY_BITS  = 16;
    localparam int POS_W     = 32;
    localparam int RANK_W    = 32;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int MOD_CNT_W = $clog2(POS_W);

    localparam logic [RANK_W-1:0] RANK_LOWEST = {1'b1, {(RANK_W-1){1'b0}}};

    // command codes
    localparam logic [3:0] CMD_CREATE  = 4'd0;
    localparam logic [3:0] CMD_DESTROY = 4'd1;
    localparam logic [3:0] CMD_RETIME  = 4'd2;
    localparam logic [3:0] CMD_REORDER = 4'd3;
    localparam logic [3:0] CMD_SEEK    = 4'd4;
    localparam logic [3:0] CMD_START   = 4'd5;
    localparam logic [3:0] CMD_STOP    = 4'd6;
    localparam logic [3:0] CMD_ADVANCE = 4'd7;
    localparam logic [3:0] CMD_FIRE    = 4'd8;
    localparam logic [3:0] CMD_QUERY   = 4'd9;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_LOOP_START  = 2'd0;
    localparam logic [1:0] CFG_LOOP_SPAN   = 2'd1;
    localparam logic [1:0] CFG_LOOP_ENABLE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_EXEC, S_SWEEP, S_WRAP, S_NSCAN, S_PICK, S_OUT
    } t_state;

    typedef struct packed {
        logic                ss;
        logic [KEY_BITS-1:0] key;
        logic [POS_W-1:0]    pos;
        logic [RANK_W-1:0]   rank;
    } t_ent;

    typedef struct packed {
        logic                vld;
        logic                ss;
        logic [IDX_W-1:0]    idx;
        logic [KEY_BITS-1:0] key;
        logic [POS_W-1:0]    pos;
        logic [RANK_W-1:0]   rank;
    } t_cand;

    // order by (position, rank, key)
    function automatic logic key_less(
        input logic [POS_W:0]        w1,
        input logic signed [RANK_W-1:0] r1,
        input logic [KEY_BITS-1:0]   k1,
        input logic [POS_W:0]        w2,
        input logic signed [RANK_W-1:0] r2,
        input logic [KEY_BITS-1:0]   k2
    );
        logic res;
        if (w1 != w2) begin
            res = w1 < w2;
        end else if (r1 != r2) begin
            res = r1 < r2;
        end else begin
            res = k1 < k2;
        end
        return res;
    endfunction

    // keep the earlier of candidate and element when the element qualifies
    function automatic t_cand cand_pick(input t_cand c, input logic cond, input t_cand e);
        t_cand res;
        res = c;
        if (cond && (!c.vld || key_less({1'b0, e.pos}, e.rank, e.key,
                                          {1'b0, c.pos}, c.rank, c.key))) begin
            res = e;
        end
        return res;
    endfunction

endpackage

@@ sv/looping_timeline_task_scheduler_top.sv @@
// Timeline task scheduler: task table memory, scan sequencer and serial modulo.
// Depends on ltts_pkg.
//
// Usage
//   Request channel: i_valid / o_stall with i_cmd, i_task_key, i_single_shot,
//   i_when, i_rank, i_step_length. A request is taken when i_valid is high
//   and o_stall is low. One result per request leaves on o_valid / i_stall.
//   Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index, i_cfg_data.
//   A write that re-wraps the position over a nonzero span busies the block for a bit-serial modulo.
// Sequence
//   Tasks live in a 64-entry memory with a registered read. Each request
//   runs a lookup scan of the table, an execute step, a final scan for the
//   next due task, then a pick state and an output state that registers the
//   result. A seek or advance that moves the position adds a sweep of the
//   memory and, when the position wraps, a bit-serial modulo.
//   The memory scans set the rate: one entry per cycle.
// Reset
//   Synchronous, active low: the table reads empty at once (per-entry used
//   bits), the position is 0, the timeline is stopped, the loop is off.
// Stall
//   A finished result waits in the output register while i_stall is high;
//   the next request is taken and worked meanwhile, and its result waits in
//   the final state until the output register frees.
module looping_timeline_task_scheduler_top
    import ltts_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [3:0]               i_cmd,
    input  logic [KEY_BITS-1:0]      i_task_key,
    input  logic                     i_single_shot,
    input  logic [POS_W-1:0]         i_when,
    input  logic signed [RANK_W-1:0] i_rank,
    input  logic [POS_W-1:0]         i_step_length,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [POS_W-1:0]         i_cfg_data,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [1:0]               o_status,
    output logic [KEY_BITS-1:0]      o_fired_key,
    output logic [POS_W-1:0]         o_task_when,
    output logic signed [RANK_W-1:0] o_task_rank,
    output logic                     o_next_valid,
    output logic [POS_W-1:0]         o_next_distance,
    output logic signed [RANK_W-1:0] o_next_rank,
    output logic                     o_running,
    output logic [POS_W-1:0]         o_now_position
);

    t_state r_state, n_state;

    // task table
    t_ent                 r_mem [MAX_TASKS];
    t_ent                 r_rdata;
    logic [MAX_TASKS-1:0] r_used;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_wa;
    t_ent                 mem_wd;
    logic                 used_we;
    logic [IDX_W-1:0]     used_wa;
    logic                 used_wd;

    // timeline state and configuration
    logic [POS_W-1:0] r_pp, r_lfp, r_ls, r_span;
    logic             r_lfv, r_playing, r_le;

    // captured request
    logic [3:0]          r_cmd;
    logic [KEY_BITS-1:0] r_key;
    logic                r_ss;
    logic [POS_W-1:0]    r_when, r_step;
    logic [RANK_W-1:0]   r_rank;

    // scan
    logic [CNT_W-1:0] r_cnt;
    t_cand            r_m, r_co, r_ca, r_cb, r_cc;
    logic             r_free_vld;
    logic [IDX_W-1:0] r_free_idx;

    // seek
    logic [POS_W-1:0] r_tgt;
    logic [POS_W:0]   r_thr;
    logic             r_move;

    // modulo
    logic [POS_W-1:0]     r_mod_x, r_mod_rem;
    logic [MOD_CNT_W-1:0] r_mod_cnt;
    logic                 r_wrap_cfg;

    // result
    logic [1:0]          r_status;
    logic [KEY_BITS-1:0] r_fired;
    logic [POS_W-1:0]    r_qwhen;
    logic [RANK_W-1:0]   r_qrank;
    logic                r_have;
    logic [POS_W:0]      r_nw;
    logic [RANK_W-1:0]   r_nr;
    logic [KEY_BITS-1:0] r_nk;
    logic                r_out_vld;
    logic [1:0]          r_o_status;
    logic [KEY_BITS-1:0] r_o_fired;
    logic [POS_W-1:0]    r_o_qwhen, r_o_dist, r_o_pp;
    logic [RANK_W-1:0]   r_o_qrank, r_o_nr;
    logic                r_o_nv, r_o_run;

    logic in_acc, cfg_fire, scan_on, scan_last, out_free, mod_last;
    logic [IDX_W-1:0] scan_j;
    t_cand            e_c, rsel;
    logic             e_used;

    // ---------------- handshake and scan indexing ----------------
    assign in_acc    = i_valid && !o_stall;
    assign cfg_fire  = i_cfg_valid && o_cfg_ready;
    assign scan_on   = (r_cnt != '0);
    assign scan_last = (r_cnt == CNT_W'(MAX_TASKS));
    assign scan_j    = IDX_W'(r_cnt - CNT_W'(1));
    assign out_free  = !r_out_vld || !i_stall;
    assign mod_last  = (r_mod_cnt == MOD_CNT_W'(POS_W - 1));
    assign e_used    = r_used[scan_j];

    always_comb begin
        e_c      = '0;
        e_c.vld  = 1'b1;
        e_c.ss   = r_rdata.ss;
        e_c.idx  = scan_j;
        e_c.key  = r_rdata.key;
        e_c.pos  = r_rdata.pos;
        e_c.rank = r_rdata.rank;
    end

    // pick the next recurring task from the scan candidates
    always_comb begin
        rsel = r_ca;
        if (r_ca.vld && r_lfv && r_ca.pos == r_lfp) begin
            rsel = r_cb;
        end
        if (!rsel.vld && r_le) begin
            rsel = r_cc;
        end
    end

    // ---------------- configuration decode ----------------
    logic [POS_W-1:0] cfg_ls, cfg_span;
    logic             cfg_le, cfg_chg, cfg_wrap;

    always_comb begin
        cfg_ls   = r_ls;
        cfg_span = r_span;
        cfg_le   = r_le;
        cfg_chg  = 1'b0;
        case (i_cfg_index)
            CFG_LOOP_START: begin
                cfg_ls  = i_cfg_data;
                cfg_chg = (i_cfg_data != r_ls);
            end
            CFG_LOOP_SPAN: begin
                cfg_span = i_cfg_data;
                cfg_chg  = (i_cfg_data != r_span);
            end
            CFG_LOOP_ENABLE: begin
                cfg_le  = i_cfg_data[0];
                cfg_chg = (i_cfg_data[0] != r_le);
            end
            default: cfg_chg = 1'b0;
        endcase
        cfg_wrap = cfg_fire && cfg_chg && cfg_le && (r_pp > cfg_ls);
    end

    // ---------------- execute decode ----------------
    logic [1:0]       ex_status;
    logic             ex_create, ex_destroy, ex_retime, ex_reorder, ex_seek;
    logic             ex_fire_o, ex_fire_r, ex_start, ex_stop, ex_query;
    logic [POS_W:0]   ex_sum, ex_end;
    logic [POS_W-1:0] ex_p;
    logic             keyed;

    always_comb begin
        ex_status  = ST_OK;
        ex_create  = 1'b0;
        ex_destroy = 1'b0;
        ex_retime  = 1'b0;
        ex_reorder = 1'b0;
        ex_seek    = 1'b0;
        ex_fire_o  = 1'b0;
        ex_fire_r  = 1'b0;
        ex_start   = 1'b0;
        ex_stop    = 1'b0;
        ex_query   = 1'b0;
        ex_sum     = {1'b0, r_pp} + {1'b0, r_step};
        ex_p       = r_when;
        ex_end     = {1'b0, r_ls} + {1'b0, r_span};
        keyed      = (r_cmd == CMD_CREATE) || (r_cmd == CMD_DESTROY) ||
                     (r_cmd == CMD_RETIME) || (r_cmd == CMD_REORDER) || (r_cmd == CMD_QUERY);
        if (r_cmd == CMD_ADVANCE) begin
            ex_p = ex_sum[POS_W] ? '1 : ex_sum[POS_W-1:0];
        end
        if (keyed && r_key == '0) begin
            ex_status = ST_INVALID;
        end else if (keyed && !r_m.vld && r_cmd != CMD_CREATE) begin
            ex_status = ST_NOTFOUND;
        end else begin
            case (r_cmd)
                CMD_CREATE: begin
                    if (r_m.vld || (r_ss && r_when < r_pp)) ex_status = ST_INVALID;
                    else if (!r_free_vld)                   ex_status = ST_FULL;
                    else                                    ex_create = 1'b1;
                end
                CMD_DESTROY: ex_destroy = 1'b1;
                CMD_RETIME: begin
                    if (r_m.ss && r_when < r_pp) ex_status = ST_INVALID;
                    else                         ex_retime = 1'b1;
                end
                CMD_REORDER: ex_reorder = 1'b1;
                CMD_SEEK:    ex_seek = (ex_p != r_pp);
                CMD_START:   ex_start = 1'b1;
                CMD_STOP:    ex_stop = 1'b1;
                CMD_ADVANCE: ex_seek = r_playing && (ex_p != r_pp);
                CMD_FIRE: begin
                    if (r_playing) begin
                        if (r_co.vld && r_co.pos == r_pp)   ex_fire_o = 1'b1;
                        else if (rsel.vld && rsel.pos == r_pp) ex_fire_r = 1'b1;
                    end
                end
                CMD_QUERY: ex_query = 1'b1;
                default:   ex_status = ST_INVALID;
            endcase
        end
    end

    // ---------------- sweep and modulo step ----------------
    logic           sw_drop, sw_move;
    logic [POS_W:0] mod_t, mod_n;

    always_comb begin
        sw_drop = scan_on && e_used && r_rdata.ss && ({1'b0, r_rdata.pos} < r_thr);
        sw_move = scan_on && e_used && r_rdata.ss && !sw_drop && r_move;
        mod_t   = {r_mod_rem, r_mod_x[POS_W-1]};
        mod_n   = (mod_t >= {1'b0, r_span}) ? mod_t - {1'b0, r_span} : mod_t;
    end

    // ---------------- result selection ----------------
    logic             take_o, res_have;
    logic [POS_W:0]   res_w, res_d;
    logic [RANK_W-1:0] res_r;
    logic [POS_W-1:0] res_dist;
    logic [POS_W:0]   pick_w;

    always_comb begin
        pick_w = {1'b0, rsel.pos};
        if (r_le && (rsel.pos < r_pp || (r_lfv && rsel.pos == r_lfp))) begin
            pick_w = {1'b0, rsel.pos} + {1'b0, r_span};
        end
        take_o   = r_co.vld && (!r_have || key_less({1'b0, r_co.pos}, r_co.rank, r_co.key,
                                                   r_nw, r_nr, r_nk));
        res_w    = take_o ? {1'b0, r_co.pos} : r_nw;
        res_r    = take_o ? r_co.rank : r_nr;
        res_have = r_playing && (take_o || r_have);
        res_d    = res_w - {1'b0, r_pp};
        if (res_w <= {1'b0, r_pp}) res_dist = '0;
        else if (res_d[POS_W])     res_dist = '1;
        else                       res_dist = res_d[POS_W-1:0];
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc)                                 n_state = S_LOOK;
                else if (cfg_wrap && cfg_span != '0)        n_state = S_WRAP;
            end
            S_LOOK:  if (scan_last) n_state = S_EXEC;
            S_EXEC:  n_state = ex_seek ? S_SWEEP : S_NSCAN;
            S_SWEEP: begin
                if (scan_last) n_state = (r_move && r_span != '0) ? S_WRAP : S_NSCAN;
            end
            S_WRAP:  if (mod_last) n_state = r_wrap_cfg ? S_IDLE : S_NSCAN;
            S_NSCAN: if (scan_last) n_state = S_PICK;
            S_PICK:  n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- outputs and memory write selection ----------------
    always_comb begin
        o_stall     = (r_state != S_IDLE) || i_cfg_valid;
        o_cfg_ready = (r_state == S_IDLE);
        mem_we      = 1'b0;
        mem_wa      = scan_j;
        mem_wd      = '0;
        used_we     = 1'b0;
        used_wa     = scan_j;
        used_wd     = 1'b0;
        case (r_state)
            S_EXEC: begin
                if (ex_create) begin
                    mem_we  = 1'b1;
                    mem_wa  = r_free_idx;
                    mem_wd  = '{ss: r_ss, key: r_key, pos: r_when, rank: r_rank};
                    used_we = 1'b1;
                    used_wa = r_free_idx;
                    used_wd = 1'b1;
                end else if (ex_retime || ex_reorder) begin
                    mem_we = 1'b1;
                    mem_wa = r_m.idx;
                    mem_wd = '{ss: r_m.ss, key: r_key,
                               pos: ex_retime ? r_when : r_m.pos,
                               rank: ex_reorder ? r_rank : r_m.rank};
                end else if (ex_destroy) begin
                    used_we = 1'b1;
                    used_wa = r_m.idx;
                end else if (ex_fire_o) begin
                    used_we = 1'b1;
                    used_wa = r_co.idx;
                end
            end
            S_SWEEP: begin
                used_we = sw_drop;
                mem_we  = sw_move;
                mem_wd  = '{ss: 1'b1, key: r_rdata.key, pos: r_ls, rank: RANK_LOWEST};
            end
            default: mem_we = 1'b0;
        endcase
    end

    assign o_valid         = r_out_vld;
    assign o_status        = r_o_status;
    assign o_fired_key     = r_o_fired;
    assign o_task_when     = r_o_qwhen;
    assign o_task_rank     = r_o_qrank;
    assign o_next_valid    = r_o_nv;
    assign o_next_distance = r_o_dist;
    assign o_next_rank     = r_o_nr;
    assign o_running       = r_o_run;
    assign o_now_position  = r_o_pp;

    // ---------------- memory: one write, one registered read ----------------
    // scans read entry j+1 while a sweep writes entry j, so accesses never meet
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[r_cnt[IDX_W-1:0]];
    end

    // ---------------- used bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (used_we) begin
            r_used[used_wa] <= used_wd;
        end
    end

    // ---------------- control state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_pp      <= '0;
            r_lfp     <= '0;
            r_lfv     <= 1'b0;
            r_playing <= 1'b0;
            r_ls      <= '0;
            r_span    <= POS_W'(65536);
            r_le      <= 1'b0;
            r_out_vld <= 1'b0;
            r_mod_cnt <= '0;
        end else begin
            r_state <= n_state;

            // advance the scan counter through the table
            if ((r_state == S_LOOK || r_state == S_SWEEP || r_state == S_NSCAN) && !scan_last) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end

            // apply configuration writes and start a re-wrap
            if (r_state == S_IDLE && cfg_fire) begin
                r_ls   <= cfg_ls;
                r_span <= cfg_span;
                r_le   <= cfg_le;
                if (cfg_wrap && cfg_span == '0) begin
                    r_pp <= cfg_ls;
                end
            end

            // timeline updates from the execute step
            if (r_state == S_EXEC) begin
                if (ex_start) begin
                    r_lfv     <= 1'b0;
                    r_playing <= 1'b1;
                end
                if (ex_stop) r_playing <= 1'b0;
                if (ex_seek) r_lfv <= 1'b0;
                if (ex_fire_r) begin
                    r_lfv <= 1'b1;
                    r_lfp <= rsel.pos;
                end
            end

            // finish a seek
            if (r_state == S_SWEEP && scan_last) begin
                if (!r_move)              r_pp <= r_tgt;
                else if (r_span == '0)    r_pp <= r_ls;
            end

            // step the modulo counter and land the wrapped position
            if (r_state == S_WRAP) begin
                r_mod_cnt <= r_mod_cnt + MOD_CNT_W'(1);
                if (mod_last) begin
                    r_pp <= r_ls + mod_n[POS_W-1:0];
                end
            end else begin
                r_mod_cnt <= '0;
            end

            // hold the result until taken
            if (r_state == S_OUT && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        // capture the request
        if (in_acc) begin
            r_cmd  <= i_cmd;
            r_key  <= i_task_key;
            r_ss   <= i_single_shot;
            r_when <= i_when;
            r_rank <= i_rank;
            r_step <= i_step_length;
        end

        // load the modulo operands, then shift them through the modulo during a wrap
        if (r_state == S_IDLE) begin
            r_mod_x    <= r_pp - cfg_ls;
            r_mod_rem  <= '0;
            r_wrap_cfg <= 1'b1;
        end else if (r_state == S_SWEEP) begin
            r_mod_x    <= r_tgt - r_ls;
            r_mod_rem  <= '0;
            r_wrap_cfg <= 1'b0;
        end else if (r_state == S_WRAP) begin
            r_mod_x   <= {r_mod_x[POS_W-2:0], 1'b0};
            r_mod_rem <= mod_n[POS_W-1:0];
        end

        // scan: clear candidates, then fold in one entry a cycle
        if (r_state == S_LOOK || r_state == S_NSCAN) begin
            if (!scan_on) begin
                r_co.vld <= 1'b0;
                r_ca.vld <= 1'b0;
                r_cb.vld <= 1'b0;
                r_cc.vld <= 1'b0;
                if (r_state == S_LOOK) begin
                    r_m.vld    <= 1'b0;
                    r_free_vld <= 1'b0;
                end
            end else begin
                r_co <= cand_pick(r_co, e_used && r_rdata.ss, e_c);
                r_ca <= cand_pick(r_ca, e_used && !r_rdata.ss && r_rdata.pos >= r_pp, e_c);
                r_cb <= cand_pick(r_cb, e_used && !r_rdata.ss && r_rdata.pos > r_lfp, e_c);
                r_cc <= cand_pick(r_cc, e_used && !r_rdata.ss && r_rdata.pos >= r_ls, e_c);
                if (r_state == S_LOOK) begin
                    if (e_used && r_rdata.key == r_key) r_m <= e_c;
                    if (!e_used && !r_free_vld) begin
                        r_free_vld <= 1'b1;
                        r_free_idx <= scan_j;
                    end
                end
            end
        end

        // execute: result fields and seek setup
        if (r_state == S_EXEC) begin
            r_status <= ex_status;
            r_fired  <= ex_fire_o ? r_co.key : (ex_fire_r ? rsel.key : '0);
            r_qwhen  <= ex_query ? r_m.pos : '0;
            r_qrank  <= ex_query ? r_m.rank : '0;
            r_tgt    <= ex_p;
            r_move   <= r_le && ({1'b0, ex_p} >= ex_end);
            r_thr    <= (r_le && ex_end < {1'b0, ex_p}) ? ex_end : {1'b0, ex_p};
        end

        // register the next recurring task
        if (r_state == S_PICK) begin
            r_have <= rsel.vld;
            r_nw   <= pick_w;
            r_nr   <= rsel.rank;
            r_nk   <= rsel.key;
        end

        // load the output register
        if (r_state == S_OUT && out_free) begin
            r_o_status <= r_status;
            r_o_fired  <= r_fired;
            r_o_qwhen  <= r_qwhen;
            r_o_qrank  <= r_qrank;
            r_o_nv     <= res_have;
            r_o_dist   <= res_have ? res_dist : '0;
            r_o_nr     <= res_have ? res_r : '0;
            r_o_run    <= r_playing;
            r_o_pp     <= r_pp;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_TASKS))
        else $error("scan counter past table end");

    a_sweep_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && mem_we) |-> r_move)
        else $error("sweep wrote an entry without a loop move");

    a_wrap_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRAP && mod_last) |=> (r_pp >= r_ls))
        else $error("wrapped position below loop start");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> (o_valid && r_state == S_IDLE))
        else $error("result not presented after final step");
`endif

endmodule

@@ tb/looping_timeline_task_scheduler_top_test.sv @@
// Self-checking testbench for looping_timeline_task_scheduler_top.
// It predicts results from its own copy of the task table; directed requests may fix the expected status.
// Depends on ltts_pkg and the scheduler top level.
module looping_timeline_task_scheduler_top_test;
    import ltts_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct {
        logic [3:0]               cmd;
        logic [KEY_BITS-1:0]      key;
        logic                     ss;
        logic [POS_W-1:0]         when;
        logic signed [RANK_W-1:0] rank;
        logic [POS_W-1:0]         step;
        bit                       has_st;
        logic [1:0]               st;
    } sched_req_t;

    typedef struct {
        logic [1:0]               status;
        logic [KEY_BITS-1:0]      fired;
        logic [POS_W-1:0]         qwhen;
        logic signed [RANK_W-1:0] qrank;
        logic                     nvalid;
        logic [POS_W-1:0]         ndist;
        logic signed [RANK_W-1:0] nrank;
        logic                     run;
        logic [POS_W-1:0]         now;
    } sched_rsp_t;

    localparam u64_t M32 = 64'hFFFF_FFFF;
    localparam int   LAT = 300;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic [3:0]               i_cmd = '0;
    logic [KEY_BITS-1:0]      i_task_key = '0;
    logic                     i_single_shot = 1'b0;
    logic [POS_W-1:0]         i_when = '0;
    logic signed [RANK_W-1:0] i_rank = '0;
    logic [POS_W-1:0]         i_step_length = '0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [1:0]               i_cfg_index = '0;
    logic [POS_W-1:0]         i_cfg_data = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [1:0]               o_status;
    logic [KEY_BITS-1:0]      o_fired_key;
    logic [POS_W-1:0]         o_task_when;
    logic signed [RANK_W-1:0] o_task_rank;
    logic                     o_next_valid;
    logic [POS_W-1:0]         o_next_distance;
    logic signed [RANK_W-1:0] o_next_rank;
    logic                     o_running;
    logic [POS_W-1:0]         o_now_position;

    looping_timeline_task_scheduler_top u_top (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow task table and timeline
    bit            tb_used [MAX_TASKS];
    bit            tb_ss   [MAX_TASKS];
    logic [15:0]   tb_key  [MAX_TASKS];
    u64_t          tb_when [MAX_TASKS];
    longint        tb_rank [MAX_TASKS];
    u64_t          play_pos, fired_pos, lp_start, lp_span;
    bit            fired_vld, playing, lp_en;

    sched_rsp_t    pending_rsp[$];
    int            err_cnt = 0;
    int            stall_mode = 0;

    function automatic bit order_less(u64_t w1, longint r1, u64_t k1,
                                      u64_t w2, longint r2, u64_t k2);
        if (w1 != w2) return w1 < w2;
        if (r1 != r2) return r1 < r2;
        return k1 < k2;
    endfunction

    function automatic int first_task(bit one_off, u64_t lb);
        int best;
        best = -1;
        for (int i = 0; i < MAX_TASKS; i++) begin
            if (!tb_used[i] || tb_ss[i] != one_off || tb_when[i] < lb) continue;
            if (best < 0 || order_less(tb_when[i], tb_rank[i], tb_key[i],
                                       tb_when[best], tb_rank[best], tb_key[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic int find_task(logic [15:0] k);
        for (int i = 0; i < MAX_TASKS; i++)
            if (tb_used[i] && tb_key[i] == k) return i;
        return -1;
    endfunction

    function automatic u64_t wrap_pos(u64_t p);
        if (lp_span == 0) return lp_start;
        return lp_start + (p - lp_start) % lp_span;
    endfunction

    function automatic void rewrap();
        if (lp_en && play_pos > lp_start) play_pos = wrap_pos(play_pos);
    endfunction

    function automatic int next_recurring();
        int i;
        i = first_task(1'b0, play_pos);
        if (i >= 0 && fired_vld && tb_when[i] == fired_pos)
            i = first_task(1'b0, fired_pos + 1);
        if (i < 0 && lp_en) i = first_task(1'b0, lp_start);
        return i;
    endfunction

    function automatic void seek_to(u64_t p);
        u64_t loop_end, thr;
        loop_end = lp_start + lp_span;
        thr = (lp_en && loop_end < p) ? loop_end : p;
        if (p == play_pos) return;
        fired_vld = 1'b0;
        for (int i = 0; i < MAX_TASKS; i++)
            if (tb_used[i] && tb_ss[i] && tb_when[i] < thr) tb_used[i] = 1'b0;
        if (lp_en && p >= loop_end) begin
            for (int i = 0; i < MAX_TASKS; i++)
                if (tb_used[i] && tb_ss[i]) begin
                    tb_when[i] = lp_start;
                    tb_rank[i] = -64'sd2147483648;
                end
            play_pos = wrap_pos(p);
        end else begin
            play_pos = p;
        end
    endfunction

    function automatic void write_loop_reg(logic [1:0] idx, logic [31:0] val);
        if (idx == CFG_LOOP_START) begin
            if (val != lp_start) begin lp_start = val; rewrap(); end
        end else if (idx == CFG_LOOP_SPAN) begin
            if (val != lp_span) begin lp_span = val; rewrap(); end
        end else if (idx == CFG_LOOP_ENABLE) begin
            if (val[0] != lp_en) begin lp_en = val[0]; rewrap(); end
        end
    endfunction

    // advance the shadow state by one request and return its result
    function automatic sched_rsp_t schedule_step(sched_req_t rq);
        sched_rsp_t r;
        int slot, o, n;
        bit keyed, have;
        u64_t nw, nk, p;
        longint nr;
        r = '{default: '0};
        slot = -1;
        keyed = (rq.cmd <= CMD_REORDER) || rq.cmd == CMD_QUERY;
        if (keyed) begin
            if (rq.key == 0) r.status = ST_INVALID;
            else begin
                slot = find_task(rq.key);
                if (rq.cmd != CMD_CREATE && slot < 0) r.status = ST_NOTFOUND;
            end
        end
        if (r.status == ST_OK) begin
            case (rq.cmd)
                CMD_CREATE: begin
                    if (slot >= 0 || (rq.ss && rq.when < play_pos)) r.status = ST_INVALID;
                    else begin
                        for (int i = 0; i < MAX_TASKS && slot < 0; i++)
                            if (!tb_used[i]) slot = i;
                        if (slot < 0) r.status = ST_FULL;
                        else begin
                            tb_used[slot] = 1'b1;
                            tb_ss[slot]   = rq.ss;
                            tb_key[slot]  = rq.key;
                            tb_when[slot] = rq.when;
                            tb_rank[slot] = rq.rank;
                        end
                    end
                end
                CMD_DESTROY: tb_used[slot] = 1'b0;
                CMD_RETIME: begin
                    if (tb_ss[slot] && rq.when < play_pos) r.status = ST_INVALID;
                    else tb_when[slot] = rq.when;
                end
                CMD_REORDER: tb_rank[slot] = rq.rank;
                CMD_SEEK: seek_to(rq.when);
                CMD_START: begin fired_vld = 1'b0; playing = 1'b1; end
                CMD_STOP: playing = 1'b0;
                CMD_ADVANCE: begin
                    if (playing) begin
                        p = play_pos + rq.step;
                        seek_to(p > M32 ? M32 : p);
                    end
                end
                CMD_FIRE: begin
                    if (playing) begin
                        o = first_task(1'b1, 0);
                        if (o >= 0 && tb_when[o] == play_pos) begin
                            r.fired = tb_key[o];
                            tb_used[o] = 1'b0;
                        end else begin
                            n = next_recurring();
                            if (n >= 0 && tb_when[n] == play_pos) begin
                                r.fired = tb_key[n];
                                fired_pos = tb_when[n];
                                fired_vld = 1'b1;
                            end
                        end
                    end
                end
                CMD_QUERY: begin
                    r.qwhen = tb_when[slot];
                    r.qrank = tb_rank[slot];
                end
                default: r.status = ST_INVALID;
            endcase
        end
        // distance to the next due task
        have = 1'b0;
        nw = 0; nk = 0; nr = 0;
        if (playing) begin
            n = next_recurring();
            o = first_task(1'b1, 0);
            if (n >= 0) begin
                nw = tb_when[n]; nr = tb_rank[n]; nk = tb_key[n];
                if (lp_en && (nw < play_pos || (fired_vld && nw == fired_pos)))
                    nw += lp_span;
                have = 1'b1;
            end
            if (o >= 0 && (!have || order_less(tb_when[o], tb_rank[o], tb_key[o],
                                               nw, nr, nk))) begin
                nw = tb_when[o]; nr = tb_rank[o];
                have = 1'b1;
            end
            if (have) r.ndist = (nw <= play_pos) ? 0 :
                                ((nw - play_pos > M32) ? M32 : nw - play_pos);
            else nr = 0;
        end
        r.nvalid = have;
        r.nrank  = nr;
        r.run    = playing;
        r.now    = play_pos;
        return r;
    endfunction

    // send one request and record its expected result on acceptance
    task automatic send_request(sched_req_t rq);
        sched_rsp_t e;
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_cmd         <= rq.cmd;
        i_task_key    <= rq.key;
        i_single_shot <= rq.ss;
        i_when        <= rq.when;
        i_rank        <= rq.rank;
        i_step_length <= rq.step;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        e = schedule_step(rq);
        if (rq.has_st) e.status = rq.st;
        pending_rsp.push_back(e);
    endtask

    task automatic idle_cycles(int n);
        @(negedge i_clk);
        i_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // drain results, then write one loop register
    task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
        idle_cycles(1);
        while (pending_rsp.size() != 0) @(negedge i_clk);
        repeat (LAT) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        write_loop_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_pos();
        u64_t p;
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return M32 - $urandom_range(0, 3);
            2: return lp_start + $urandom_range(0, 3) * 32'h8000;
            default: begin
                p = play_pos + $urandom_range(0, 32'h3_0000);
                return (p > M32) ? M32 : p;
            end
        endcase
    endfunction

    function automatic sched_req_t rand_request();
        sched_req_t rq;
        int w;
        rq = '{default: '0};
        w = $urandom_range(0, 99);
        if      (w < 22) rq.cmd = CMD_CREATE;
        else if (w < 30) rq.cmd = CMD_DESTROY;
        else if (w < 36) rq.cmd = CMD_RETIME;
        else if (w < 40) rq.cmd = CMD_REORDER;
        else if (w < 46) rq.cmd = CMD_SEEK;
        else if (w < 50) rq.cmd = CMD_START;
        else if (w < 52) rq.cmd = CMD_STOP;
        else if (w < 66) rq.cmd = CMD_ADVANCE;
        else if (w < 86) rq.cmd = CMD_FIRE;
        else if (w < 98) rq.cmd = CMD_QUERY;
        else             rq.cmd = $urandom_range(10, 15);
        w = $urandom_range(0, 49);
        rq.key  = (w == 0) ? 16'd0 : (w == 1) ? $urandom() : $urandom_range(1, 80);
        rq.ss   = $urandom_range(0, 1);
        rq.when = pick_pos();
        rq.rank = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 6) - 3;
        case ($urandom_range(0, 7))
            0: rq.step = $urandom();
            1: rq.step = 0;
            default: rq.step = $urandom_range(0, 32'h1_8000);
        endcase
        return rq;
    endfunction

    // directed requests after reset: loop off, span 0x10000
    sched_req_t dir_tab[22] = '{
        '{CMD_QUERY,   16'd5,     1'b0, 32'h0,        32'sh0,        32'h0,     1, ST_NOTFOUND},
        '{CMD_CREATE,  16'd0,     1'b0, 32'h0,        32'sh0,        32'h0,     1, ST_INVALID},
        '{CMD_CREATE,  16'd1,     1'b0, 32'h0,        32'sh0,        32'h0,     1, ST_OK},
        '{CMD_CREATE,  16'd1,     1'b1, 32'h0,        32'sh0,        32'h0,     1, ST_INVALID},
        '{CMD_CREATE,  16'hFFFF,  1'b1, 32'h1_0000,   32'sh7FFFFFFF, 32'h0,     1, ST_OK},
        '{CMD_START,   16'd0,     1'b0, 32'h0,        32'sh0,        32'h0,     0, ST_OK},
        '{CMD_FIRE,    16'd0,     1'b0, 32'h0,        32'sh0,        32'h0,     0, ST_OK},
        '{CMD_FIRE,    16'd0,     1'b0, 32'h0,        32'sh0,        32'h0,     0, ST_OK},
        '{CMD_ADVANCE, 16'd0,     1'b0, 32'h0,        32'sh0,        32'h1_0000, 0, ST_OK},
        '{CMD_FIRE,    16'd0,     1'b0, 32'h0,        32'sh0,        32'h0,     0, ST_OK},
        '{CMD_QUERY,   16'd1,     1'b0, 32'h0,        32'sh0,        32'h0,     0, ST_OK},
        '{CMD_REORDER, 16'd1,     1'b0, 32'h0,        32'sh80000000, 32'h0,     0, ST_OK},
        '{CMD_CREATE,  16'd7,     1'b1, 32'h0,        32'sh0,        32'h0,     1, ST_INVALID},
        '{CMD_RETIME,  16'd1,     1'b0, 32'hFFFF_FFFF, 32'sh0,       32'h0,     0, ST_OK},
        '{CMD_SEEK,    16'd0,     1'b0, 32'hFFFF_FFFF, 32'sh0,       32'h0,     0, ST_OK},
        '{CMD_ADVANCE, 16'd0,     1'b0, 32'h0,        32'sh0,        32'hFFFF_FFFF, 0, ST_OK},
        '{CMD_DESTROY, 16'd1,     1'b0, 32'h0,        32'sh0,        32'h0,     1, ST_OK},
        '{CMD_DESTROY, 16'd1,     1'b0, 32'h0,        32'sh0,        32'h0,     1, ST_NOTFOUND},
        '{CMD_RETIME,  16'd0,     1'b0, 32'h0,        32'sh0,        32'h0,     1, ST_INVALID},
        '{CMD_STOP,    16'd0,     1'b0, 32'h0,        32'sh0,        32'h0,     0, ST_OK},
        '{CMD_ADVANCE, 16'd0,     1'b0, 32'h0,        32'sh0,        32'h100,   0, ST_OK},
        '{4'd15,       16'hFFFF,  1'b1, 32'hFFFF_FFFF, 32'shFFFFFFFF, 32'hFFFF_FFFF, 1, ST_INVALID}
    };

    // drive the receiver stall in bursts whose density shifts over the run
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if (stall_mode == 1 && $urandom_range(0, 3) == 0)
                stall_left <= $urandom_range(0, 3);
            else if (stall_mode == 2 && $urandom_range(0, 40) == 0)
                stall_left <= $urandom_range(20, 300);
        end
    end

    task automatic check_field(string name, u64_t e, u64_t a);
        if (e != a) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
            err_cnt++;
        end
    endtask

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        sched_rsp_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected result, status %0h", $time, o_status);
                err_cnt++;
            end else begin
                e = pending_rsp.pop_front();
                check_field("status",        e.status, o_status);
                check_field("fired_key",     e.fired,  o_fired_key);
                check_field("task_when",     e.qwhen,  o_task_when);
                check_field("task_rank",     32'(e.qrank), 32'(o_task_rank));
                check_field("next_valid",    e.nvalid, o_next_valid);
                check_field("next_distance", e.ndist,  o_next_distance);
                check_field("next_rank",     32'(e.nrank), 32'(o_next_rank));
                check_field("running",       e.run,    o_running);
                check_field("now_position",  e.now,    o_now_position);
            end
        end
    end

    initial begin
        #(12 * 5_000_000);
        $display("looping_timeline_task_scheduler_top verification failed");
        $finish;
    end

    initial begin
        int burst;
        logic [31:0] cfg_val;
        for (int i = 0; i < MAX_TASKS; i++) begin
            tb_used[i] = 0; tb_ss[i] = 0; tb_key[i] = 0; tb_when[i] = 0; tb_rank[i] = 0;
        end
        play_pos = 0; fired_pos = 0; fired_vld = 0; playing = 0;
        lp_start = 0; lp_span = 32'h1_0000; lp_en = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) send_request(dir_tab[i]);

        // random phases, each under a fresh loop setting
        for (int ph = 0; ph < 8; ph++) begin
            stall_mode = ph % 3;
            case (ph)
                1: begin write_cfg(CFG_LOOP_START, 0); write_cfg(CFG_LOOP_SPAN, 32'h4_0000);
                         write_cfg(CFG_LOOP_ENABLE, 1); end
                2: write_cfg(CFG_LOOP_SPAN, 0);
                3: begin write_cfg(CFG_LOOP_START, 32'hFFFF_FFFF);
                         write_cfg(CFG_LOOP_SPAN, 32'hFFFF_FFFF); end
                4: write_cfg(CFG_LOOP_ENABLE, 0);
                default: begin
                    cfg_val = $urandom();
                    write_cfg(CFG_LOOP_START, $urandom_range(0, 1) ? cfg_val
                                                                   : play_pos[31:0]);
                    write_cfg(CFG_LOOP_SPAN, $urandom_range(1, 32'h8_0000));
                    write_cfg(CFG_LOOP_ENABLE, $urandom_range(0, 1));
                end
            endcase
            for (int n = 0; n < 240; n += burst) begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst; b++) send_request(rand_request());
                if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(0, 30));
                if ($urandom_range(0, 60) == 0) begin
                    idle_cycles(1);
                    while (pending_rsp.size() != 0) @(negedge i_clk);
                end
            end
        end

        idle_cycles(1);
        while (pending_rsp.size() != 0) @(negedge i_clk);
        repeat (LAT) @(negedge i_clk);
        if (err_cnt == 0 && pending_rsp.size() == 0) begin
            $display("looping_timeline_task_scheduler_top verification clean");
        end else begin
            $display("looping_timeline_task_scheduler_top verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/ltts_pkg.sv
sv/looping_timeline_task_scheduler_top.sv
tb/looping_timeline_task_scheduler_top_test.sv
